// ===== rtl/mlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mlsm_pkg
// Shared constants, codes and helper functions for the mip level size matcher.
// ----------------------------------------------------------------------------
package mlsm_pkg;

    // number of mip levels checked when the declared level does not match
    localparam int unsigned LEVELS_SEARCHED_DEF = 16;
    localparam int unsigned LEVELS_MAX          = 16;
    localparam int unsigned LVL_IDX_W           = 4;

    // field widths
    localparam int unsigned DIM_W   = 16;
    localparam int unsigned LVL_W   = 8;
    localparam int unsigned FMT_W   = 3;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned PROD_W  = 2 * DIM_W;
    localparam int unsigned BYTES_W = PROD_W + 4;
    localparam int unsigned STAT_W  = 2;

    // stream packing
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 40;

    // pixel format classes
    localparam logic [FMT_W-1:0] FMT_DXT1  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_DXT25 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_B1    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_B2    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_B3    = 3'd4;
    localparam logic [FMT_W-1:0] FMT_B4    = 3'd5;
    localparam logic [FMT_W-1:0] FMT_B8    = 3'd6;

    // match status codes
    localparam logic [STAT_W-1:0] ST_DECLARED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RECOVERED = 2'd1;
    localparam logic [STAT_W-1:0] ST_NONE      = 2'd2;

    // dimension at a mip level, clamped to one
    function automatic logic [DIM_W-1:0] dim_at(input logic [DIM_W-1:0] base,
                                                input logic [LVL_W-1:0] lvl);
        logic [DIM_W-1:0] d;
        d = (lvl >= 8'd16) ? '0 : (base >> lvl[LVL_IDX_W-1:0]);
        if (d == '0) begin
            d = 16'd1;
        end
        return d;
    endfunction

    // pixels for plain classes, 4x4 blocks for compressed classes
    function automatic logic [DIM_W-1:0] unit_cnt(input logic [FMT_W-1:0] fmt,
                                                  input logic [DIM_W-1:0] d);
        logic [DIM_W:0] r;
        r = {1'b0, d} + 17'd3;
        if (fmt == FMT_DXT1 || fmt == FMT_DXT25) begin
            return {1'b0, r[DIM_W:2]};
        end
        return d;
    endfunction

    // unit count times bytes per unit
    function automatic logic [BYTES_W-1:0] scale_bytes(input logic [FMT_W-1:0]  fmt,
                                                       input logic [PROD_W-1:0] p);
        logic [BYTES_W-1:0] b;
        case (fmt)
            FMT_DXT1, FMT_B8: b = {1'b0, p, 3'b0};
            FMT_DXT25:        b = {p, 4'b0};
            FMT_B1:           b = {4'b0, p};
            FMT_B2:           b = {3'b0, p, 1'b0};
            FMT_B3:           b = {4'b0, p} + {3'b0, p, 1'b0};
            FMT_B4:           b = {2'b0, p, 2'b0};
            default:          b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/mip_level_size_matcher.sv =====
// An accepted input is registered in stages a, b, c, d and e before o_m_tvalid.
// Throughput: one transaction per cycle unless stalled; all levels are sized side
// by side in parallel lanes (one 16x16 multiplier per lane) through five register
// stages. Backpressure stalls only the stages behind an occupied stage, so
// bubbles fill. Reset (i_rst_n low at a clock edge) clears stage valid bits only.
// ----------------------------------------------------------------------------
// mip_level_size_matcher
// Computes mip surface sizes and picks the level that matches the byte count.
// ----------------------------------------------------------------------------
module mip_level_size_matcher #(
    parameter int unsigned LEVELS_SEARCHED = mlsm_pkg::LEVELS_SEARCHED_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // base_width, base_height, declared_level, data_size
    input  logic [mlsm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // format_class
    input  logic [mlsm_pkg::FMT_W-1:0]       i_s_tuser,
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // surface_width, surface_height, chosen_level
    output logic [mlsm_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // match_status
    output logic [mlsm_pkg::STAT_W-1:0]      o_m_tuser
);
    import mlsm_pkg::*;

    // lanes 0 .. N-1 are searched levels, lane N is the declared level
    localparam int unsigned N = LEVELS_SEARCHED;

    // input field split
    logic [DIM_W-1:0]  s_bw;
    logic [DIM_W-1:0]  s_bh;
    logic [LVL_W-1:0]  s_lvl;
    logic [SIZE_W-1:0] s_size;

    assign s_bw   = i_s_tdata[15:0];
    assign s_bh   = i_s_tdata[31:16];
    assign s_lvl  = i_s_tdata[39:32];
    assign s_size = i_s_tdata[71:40];

    // stage enables, each stage moves when empty or when the next one moves
    logic en_a, en_b, en_c, en_d, en_e;
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_m_vld;

    assign en_e       = !r_m_vld || i_m_tready;
    assign en_d       = !r_d_vld || en_e;
    assign en_c       = !r_c_vld || en_d;
    assign en_b       = !r_b_vld || en_c;
    assign en_a       = !r_a_vld || en_b;
    assign o_s_tready = en_a;

    // stage a: per-lane unit counts
    logic [DIM_W-1:0]  r_a_ua [0:N];
    logic [DIM_W-1:0]  r_a_ub [0:N];
    logic [FMT_W-1:0]  r_a_fmt;
    logic [LVL_W-1:0]  r_a_lvl;
    logic [SIZE_W-1:0] r_a_size;
    logic [DIM_W-1:0]  r_a_bw, r_a_bh;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            for (int l = 0; l < N; l++) begin
                r_a_ua[l] <= unit_cnt(i_s_tuser, dim_at(s_bw, LVL_W'(l)));
                r_a_ub[l] <= unit_cnt(i_s_tuser, dim_at(s_bh, LVL_W'(l)));
            end
            r_a_ua[N] <= unit_cnt(i_s_tuser, dim_at(s_bw, s_lvl));
            r_a_ub[N] <= unit_cnt(i_s_tuser, dim_at(s_bh, s_lvl));
            r_a_fmt   <= i_s_tuser;
            r_a_lvl   <= s_lvl;
            r_a_size  <= s_size;
            r_a_bw    <= s_bw;
            r_a_bh    <= s_bh;
        end
    end

    // stage b: per-lane unit products
    logic [PROD_W-1:0] r_b_prod [0:N];
    logic [FMT_W-1:0]  r_b_fmt;
    logic [LVL_W-1:0]  r_b_lvl;
    logic [SIZE_W-1:0] r_b_size;
    logic [DIM_W-1:0]  r_b_bw, r_b_bh;

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            for (int l = 0; l <= N; l++) begin
                r_b_prod[l] <= {{DIM_W{1'b0}}, r_a_ua[l]} * {{DIM_W{1'b0}}, r_a_ub[l]};
            end
            r_b_fmt  <= r_a_fmt;
            r_b_lvl  <= r_a_lvl;
            r_b_size <= r_a_size;
            r_b_bw   <= r_a_bw;
            r_b_bh   <= r_a_bh;
        end
    end

    // stage c: byte counts compared against the stored size
    logic [N:0]       r_c_hit;
    logic [LVL_W-1:0] r_c_lvl;
    logic [DIM_W-1:0] r_c_bw, r_c_bh;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            for (int l = 0; l <= N; l++) begin
                r_c_hit[l] <= (scale_bytes(r_b_fmt, r_b_prod[l]) == {4'b0, r_b_size});
            end
            r_c_lvl <= r_b_lvl;
            r_c_bw  <= r_b_bw;
            r_c_bh  <= r_b_bh;
        end
    end

    // stage d: nearest hit below and above the declared level
    logic                 n_lo_fnd, n_hi_fnd;
    logic [LVL_IDX_W-1:0] n_lo_l, n_hi_l;

    always_comb begin
        n_lo_fnd = 1'b0;
        n_hi_fnd = 1'b0;
        n_lo_l   = '0;
        n_hi_l   = '0;
        for (int l = 0; l < N; l++) begin
            if (r_c_hit[l] && (LVL_W'(l) < r_c_lvl)) begin
                n_lo_fnd = 1'b1;
                n_lo_l   = LVL_IDX_W'(l);
            end
        end
        for (int l = N - 1; l >= 0; l--) begin
            if (r_c_hit[l] && (LVL_W'(l) > r_c_lvl)) begin
                n_hi_fnd = 1'b1;
                n_hi_l   = LVL_IDX_W'(l);
            end
        end
    end

    logic                 r_d_decl, r_d_lo_fnd, r_d_hi_fnd;
    logic [LVL_IDX_W-1:0] r_d_lo_l, r_d_hi_l;
    logic [LVL_W-1:0]     r_d_lo_dl, r_d_hi_dl;
    logic [LVL_W-1:0]     r_d_lvl;
    logic [DIM_W-1:0]     r_d_bw, r_d_bh;

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_decl   <= r_c_hit[N];
            r_d_lo_fnd <= n_lo_fnd;
            r_d_hi_fnd <= n_hi_fnd;
            r_d_lo_l   <= n_lo_l;
            r_d_hi_l   <= n_hi_l;
            r_d_lo_dl  <= r_c_lvl - {4'b0, n_lo_l};
            r_d_hi_dl  <= {4'b0, n_hi_l} - r_c_lvl;
            r_d_lvl    <= r_c_lvl;
            r_d_bw     <= r_c_bw;
            r_d_bh     <= r_c_bh;
        end
    end

    // stage e: final choice, ties go to the lower level
    logic                 n_pick_lo;
    logic [LVL_W-1:0]     n_lvl;
    logic [STAT_W-1:0]    n_stat;
    logic [DIM_W-1:0]     n_w, n_h;

    always_comb begin
        n_pick_lo = r_d_lo_fnd && (!r_d_hi_fnd || (r_d_lo_dl <= r_d_hi_dl));
        if (r_d_decl) begin
            n_lvl  = r_d_lvl;
            n_stat = ST_DECLARED;
        end else if (r_d_lo_fnd || r_d_hi_fnd) begin
            n_lvl  = {4'b0, (n_pick_lo ? r_d_lo_l : r_d_hi_l)};
            n_stat = ST_RECOVERED;
        end else begin
            n_lvl  = '0;
            n_stat = ST_NONE;
        end
        if (n_stat == ST_NONE) begin
            n_w = '0;
            n_h = '0;
        end else begin
            n_w = dim_at(r_d_bw, n_lvl);
            n_h = dim_at(r_d_bh, n_lvl);
        end
    end

    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [STAT_W-1:0]    r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_m_tdata <= {n_lvl, n_h, n_w};
            r_m_tuser <= n_stat;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_m_vld <= 1'b0;
        end else begin
            if (en_a) r_a_vld <= i_s_tvalid;
            if (en_b) r_b_vld <= r_a_vld;
            if (en_c) r_c_vld <= r_b_vld;
            if (en_d) r_d_vld <= r_c_vld;
            if (en_e) r_m_vld <= r_d_vld;
        end
    end

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // a skipped surface reports zero dimensions and level
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_NONE) |-> (o_m_tdata == '0))
        else $error("skipped surface with nonzero payload");

    // status is never the unused code
    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_DECLARED || o_m_tuser == ST_RECOVERED ||
                        o_m_tuser == ST_NONE))
        else $error("illegal match status");

    // a recovered level lies inside the searched range
    a_rec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_RECOVERED) |-> (o_m_tdata[39:32] < LVL_W'(N)))
        else $error("recovered level outside search range");

    // a stalled pipeline that is full refuses new input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && r_b_vld && r_c_vld && r_d_vld && r_m_vld && !i_m_tready)
            |-> !o_s_tready)
        else $error("input accepted into a full stalled pipeline");

endmodule
